// File: sv/skht_pkg.sv
// skht_pkg: shared types and constants for the string-key hash table.
// No dependencies.
`default_nettype none
package skht_pkg;
    localparam int SLOTS   = 10;
    localparam int KEY_LEN = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LEN_W   = $clog2(KEY_LEN + 1);
    localparam int POS_W   = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
    localparam int STEP_W  = $clog2(SLOTS + 3);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         key_byte;
        logic               key_last;
        logic signed [31:0] value_in;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value_out;
    } t_out;

    // reduction of both 32-bit hashes modulo SLOTS by reciprocal multiply
    typedef struct packed {
        logic              start;
        logic [31:0]       sum;
        logic [31:0]       mix;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] h1;
        logic [SLOT_W-1:0] h2;
    } t_mod_rsp;
endpackage
`default_nettype wire

// File: sv/string_key_hash_table.sv
// string_key_hash_table: top level, key capture, probe sequencer, slot store.
// Depends on skht_pkg and skht_mod.
//
// channel  dir  signals                     beat
// input    in   i_valid/o_ready/i_data      one key byte (+ op on last)
// result   out  o_valid/i_ready/o_data      status and value per operation
//
// A non-last byte updates the key capture. On the last byte the hash reducer
// runs, then the probe sequencer takes up to SLOTS+2 probe steps, each used,
// same-length slot adding a key comparison (the shared byte comparator), and an
// insert copies the key bytes into the slot. The output state then raises o_valid.
// Reset (synchronous) clears the slot used bits and the pending key. The result
// sits in an output register; the block takes no byte until it has been taken.
`default_nettype none
module string_key_hash_table (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire skht_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output skht_pkg::t_out      o_data
);
    localparam int SW = skht_pkg::SLOT_W;
    localparam int LW = skht_pkg::LEN_W;
    localparam int PW = skht_pkg::POS_W;
    localparam int TW = skht_pkg::STEP_W;
    localparam int KL = skht_pkg::KEY_LEN;
    localparam int NS = skht_pkg::SLOTS;
    localparam int CW = $clog2(NS * KL);

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_HASH    = 3'd1;
    localparam logic [2:0] S_PROBE   = 3'd2;
    localparam logic [2:0] S_CMP     = 3'd3;
    localparam logic [2:0] S_COPY    = 3'd4;
    localparam logic [2:0] S_OUT     = 3'd5;

    logic [2:0] r_state;
    // key capture
    logic [7:0]    r_pend [KL];
    logic [LW-1:0] r_len;
    logic [31:0]   r_sum, r_mix;
    logic          r_over;
    logic [1:0]    r_kind;
    logic [31:0]   r_val;
    // slot store
    logic [NS-1:0] r_used;
    logic [7:0]    r_chars [NS*KL];
    logic [LW-1:0] r_slen [NS];
    logic [31:0]   r_sval [NS];
    // sequencer
    logic [SW-1:0] r_h1, r_h2, r_slot;
    logic [TW-1:0] r_step;
    logic [LW-1:0] r_pos;
    logic [7:0]    r_rd;
    logic          r_rd_ok;
    logic          r_ovalid;
    skht_pkg::t_out r_odata;

    skht_pkg::t_mod_req w_req;
    skht_pkg::t_mod_rsp w_rsp;
    logic [SW-1:0] w_probe;
    logic [SW:0]   w_lin;
    logic [CW-1:0] w_addr;
    logic          w_accept;

    skht_mod u_mod (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign o_ready  = (r_state == S_COLLECT);
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;
    assign w_req.start = w_accept && i_data.key_last
                         && (i_data.kind != skht_pkg::KIND_UNUSED);
    assign w_req.sum   = r_sum + 32'(i_data.key_byte);
    assign w_req.mix   = r_mix + (r_mix ^ 32'(i_data.key_byte));

    // probe order: h1, h2, then h1+i wrapping
    assign w_lin = (SW+1)'(r_h1) + (SW+1)'(r_step - TW'(2));
    always_comb begin
        if (r_step == TW'(0))      w_probe = r_h1;
        else if (r_step == TW'(1)) w_probe = r_h2;
        else if (w_lin >= (SW+1)'(NS)) w_probe = SW'(w_lin - (SW+1)'(NS));
        else w_probe = SW'(w_lin);
    end
    assign w_addr = CW'(r_slot * KL) + CW'(r_pos);

    // slot byte memory: one read, one write port
    always_ff @(posedge i_clk) begin
        r_rd <= r_chars[w_addr];
        if (r_state == S_COPY) r_chars[w_addr] <= r_pend[r_pos[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_COLLECT;
            r_used   <= '0;
            r_len    <= '0;
            r_sum    <= '0;
            r_mix    <= '0;
            r_over   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_COLLECT: begin
                    if (w_accept) begin
                        if (r_len < LW'(KL)) begin
                            r_pend[r_len[PW-1:0]] <= i_data.key_byte;
                            r_len <= r_len + LW'(1);
                        end else begin
                            r_over <= 1'b1;
                        end
                        r_sum  <= w_req.sum;
                        r_mix  <= w_req.mix;
                        r_kind <= i_data.kind;
                        r_val  <= i_data.value_in;
                        if (i_data.key_last) begin
                            if (i_data.kind == skht_pkg::KIND_UNUSED) begin
                                r_len <= '0; r_sum <= '0; r_mix <= '0; r_over <= 1'b0;
                            end else begin
                                if (r_len >= LW'(KL)) r_over <= 1'b1;
                                r_state <= S_HASH;
                            end
                        end
                    end
                end
                S_HASH: begin
                    if (w_rsp.done) begin
                        r_h1 <= w_rsp.h1;
                        r_h2 <= w_rsp.h2;
                        r_step <= '0;
                        if (r_over) begin
                            r_odata <= '{skht_pkg::ST_TOO_LONG, 32'sd0};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    r_slot <= w_probe;
                    r_pos  <= '0;
                    r_rd_ok <= 1'b0;
                    if (r_step == TW'(NS + 2)) begin
                        if (r_kind == skht_pkg::KIND_INSERT)
                            r_odata <= '{skht_pkg::ST_FULL, 32'sd0};
                        else
                            r_odata <= '{skht_pkg::ST_NOT_FOUND, 32'sd0};
                        r_state <= S_OUT;
                    end else if (r_kind == skht_pkg::KIND_INSERT) begin
                        if (!r_used[w_probe]) begin
                            r_used[w_probe] <= 1'b1;
                            r_slen[w_probe] <= r_len;
                            r_sval[w_probe] <= r_val;
                            r_state <= (r_len == '0) ? S_OUT : S_COPY;
                            r_odata <= '{skht_pkg::ST_INSERTED, 32'sd0};
                        end else r_step <= r_step + TW'(1);
                    end else if (r_used[w_probe] && r_slen[w_probe] == r_len) begin
                        r_state <= S_CMP;
                    end else r_step <= r_step + TW'(1);
                end
                S_CMP: begin
                    // r_rd holds the byte at the address of the previous cycle
                    r_rd_ok <= 1'b1;
                    if (r_rd_ok) begin
                        if (r_rd != r_pend[PW'(r_pos - LW'(1))]) begin
                            r_step <= r_step + TW'(1);
                            r_state <= S_PROBE;
                        end else if (r_pos == r_len) begin
                            r_odata <= '{skht_pkg::ST_FOUND,
                                (r_kind == skht_pkg::KIND_SEARCH) ? r_sval[r_slot] : 32'sd0};
                            if (r_kind == skht_pkg::KIND_DELETE) r_used[r_slot] <= 1'b0;
                            r_state <= S_OUT;
                        end
                    end
                    if (r_pos != r_len) r_pos <= r_pos + LW'(1);
                    if (r_len == '0) begin
                        r_odata <= '{skht_pkg::ST_FOUND,
                            (r_kind == skht_pkg::KIND_SEARCH) ? r_sval[r_slot] : 32'sd0};
                        if (r_kind == skht_pkg::KIND_DELETE) r_used[r_slot] <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_COPY: begin
                    if (r_pos == r_len - LW'(1)) r_state <= S_OUT;
                    else r_pos <= r_pos + LW'(1);
                end
                S_OUT: begin
                    if (!r_ovalid) r_ovalid <= 1'b1;
                    else if (i_ready) begin
                        r_ovalid <= 1'b0;
                        r_len <= '0; r_sum <= '0; r_mix <= '0; r_over <= 1'b0;
                        r_state <= S_COLLECT;
                    end
                end
                default: r_state <= S_COLLECT;
            endcase
        end
    end

    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while result pending");
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("valid outside output state");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("result dropped");
endmodule
`default_nettype wire

// File: sv/skht_mod.sv
// skht_mod: modulo-SLOTS reduction of both key hashes, one shared reciprocal multiplier.
// Depends on skht_pkg.
`default_nettype none
module skht_mod (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire skht_pkg::t_mod_req i_req,
    output skht_pkg::t_mod_rsp      o_rsp
);
    localparam int SW = skht_pkg::SLOT_W;
    // q = (x * RM) >> (32 + RL) is the exact quotient for every 32-bit x
    localparam int RL = $clog2(skht_pkg::SLOTS);
    localparam logic [32:0] RM =
        33'((64'd1 << (32 + RL)) / 64'(skht_pkg::SLOTS) + 64'd1);

    localparam logic [1:0] PH_Q1 = 2'd0;
    localparam logic [1:0] PH_R1 = 2'd1;
    localparam logic [1:0] PH_Q2 = 2'd2;
    localparam logic [1:0] PH_R2 = 2'd3;

    logic [31:0]   r_a, r_b, r_q;
    logic [SW-1:0] r_h1, r_h2;
    logic [1:0]    r_ph;
    logic          r_busy, r_done;
    logic [64:0]   w_prod;
    logic [31:0]   w_q, w_rem;

    assign w_prod = 65'(r_a) * 65'(RM);
    assign w_q    = 32'(w_prod >> (32 + RL));
    assign w_rem  = r_a - r_q * 32'(skht_pkg::SLOTS);

    // quotient and remainder of sum, then the same for mix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= PH_Q1;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_ph   <= PH_Q1;
                r_a    <= i_req.sum;
                r_b    <= i_req.mix;
            end else if (r_busy) begin
                case (r_ph)
                    PH_Q1: begin
                        r_q  <= w_q;
                        r_ph <= PH_R1;
                    end
                    PH_R1: begin
                        r_h1 <= w_rem[SW-1:0];
                        r_a  <= r_b;
                        r_ph <= PH_Q2;
                    end
                    PH_Q2: begin
                        r_q  <= w_q;
                        r_ph <= PH_R2;
                    end
                    PH_R2: begin
                        r_h2   <= w_rem[SW-1:0];
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_ph   <= PH_Q1;
                    end
                    default: r_ph <= PH_Q1;
                endcase
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.h1   = r_h1;
    assign o_rsp.h2   = r_h2;
endmodule
`default_nettype wire
